>>> rtl/assert_macros.svh
// Assertion macros used by latlon_to_map_tile, the RTL file that carries checks.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/l2t_pkg.sv
// Shared widths, constants, stage map and types of the map tile converter.
// Depends on nothing; used by l2t_sine, l2t_log2 and latlon_to_map_tile.
package l2t_pkg;

    localparam int LAT_W   = 30;
    localparam int LON_W   = 31;
    localparam int LVL_W   = 5;
    localparam int TILE_W  = 23;
    localparam int QK_W    = 2 * TILE_W;
    localparam int MAX_LEVEL = 23;

    localparam int ANG_W   = 31;   // radians, Q30
    localparam int MAG_W   = 29;   // clamped |latitude|, Q22 degrees
    localparam int U_W     = 32;   // biased longitude
    localparam int W_W     = 31;   // column numerator >> 25
    localparam int FRAC_W  = 30;   // Q30 fraction bits
    localparam int EXP_W   = 5;    // normalize shift count
    localparam int LG_W    = 35;   // clamped log difference
    localparam int D_W     = 41;   // mercator offset, Q40
    localparam int Y_W     = 43;   // signed Y, Q40

    localparam logic [MAG_W-1:0] LAT_LIMIT = 29'd356730290;
    // degree-to-radian factor minus 2^32, the 2^32 part is added as a shift
    localparam logic [28:0]      RAD_LO    = 29'd502557221;
    localparam logic [U_W-1:0]   LON_BIAS  = 32'd754974720;
    localparam logic [21:0]      X_BIAS    = 22'd2949120;
    localparam logic [5:0]       COL_DIV   = 6'd45;
    localparam int               COL_SHF   = 35;
    localparam logic [29:0]      COL_MUL   = 30'(((64'd1 << COL_SHF) + 64'd44) / 64'd45);
    localparam logic [27:0]      MERC_C    = 28'd236905672;
    localparam int               HALF_BIT  = 39;

    localparam int SIN_TERMS = 10;
    localparam int SIN_LAT   = 2 * SIN_TERMS + 2;
    localparam int LOG_BITS  = FRAC_W;
    localparam int LOG_LAT   = LOG_BITS + 1;

    // Reciprocals of (2k)(2k+1) for the series terms, exact for 32-bit numerators.
    localparam logic [32:0] SIN_MUL [SIN_TERMS] = '{
        33'(((66'd1 << 35) + 66'd5) / 66'd6),
        33'(((66'd1 << 37) + 66'd19) / 66'd20),
        33'(((66'd1 << 38) + 66'd41) / 66'd42),
        33'(((66'd1 << 39) + 66'd71) / 66'd72),
        33'(((66'd1 << 39) + 66'd109) / 66'd110),
        33'(((66'd1 << 40) + 66'd155) / 66'd156),
        33'(((66'd1 << 40) + 66'd209) / 66'd210),
        33'(((66'd1 << 41) + 66'd271) / 66'd272),
        33'(((66'd1 << 41) + 66'd341) / 66'd342),
        33'(((66'd1 << 41) + 66'd419) / 66'd420)
    };
    localparam int SIN_SHF [SIN_TERMS] = '{35, 37, 38, 39, 39, 40, 40, 41, 41, 41};

    // Stage map of the top level pipeline.
    localparam int STG_ANGLE  = 2;
    localparam int STG_TX     = 4;
    localparam int STG_SINE   = STG_ANGLE + SIN_LAT;
    localparam int STG_LOG    = STG_SINE + LOG_LAT;
    localparam int STG_LG     = STG_LOG + 1;
    localparam int STG_D      = STG_LOG + 2;
    localparam int STG_Y      = STG_LOG + 3;
    localparam int PIPE_DEPTH = STG_LOG + 4;

    typedef struct packed {
        logic [EXP_W-1:0]  exp_neg;
        logic [FRAC_W-1:0] frac;
    } t_log;

endpackage

>>> rtl/latlon_to_map_tile.sv
// Web Mercator tile column, row and quadkey from latitude, longitude and level.
// One beat per cycle sustained while the output beat is not held by i_stall.
// The depth is set by the 10-term sine series (22 stages) and the 30-bit log
// squaring chain (31 stages); a stalled output beat holds every stage in place.
// Reset (i_rst_n low, synchronous) clears all valid bits; no clearing pass.
// Depends on l2t_pkg, l2t_sine, l2t_log2 and assert_macros.svh.
`include "assert_macros.svh"

module latlon_to_map_tile (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [l2t_pkg::LAT_W-1:0]    i_latitude,
    input  logic signed [l2t_pkg::LON_W-1:0]    i_longitude,
    input  logic        [l2t_pkg::LVL_W-1:0]    i_zoom_level,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic        [l2t_pkg::TILE_W-1:0]   o_tile_column,
    output logic        [l2t_pkg::TILE_W-1:0]   o_tile_row,
    output logic        [l2t_pkg::QK_W-1:0]     o_quad_key
);

    localparam int DEPTH = l2t_pkg::PIPE_DEPTH;

    // Pipeline control: every stage advances together unless the output
    // beat is held by the downstream side.
    logic                      w_en;
    logic [DEPTH:1]            r_vld;

    // Side lines that ride along with each beat.
    logic [l2t_pkg::LVL_W-1:0]  r_lvl_d   [1:DEPTH];
    logic                       r_south_d [1:l2t_pkg::STG_Y-1];
    logic [l2t_pkg::TILE_W-1:0] r_tx_d    [l2t_pkg::STG_TX:DEPTH-1];

    // Stage 1
    logic [l2t_pkg::LVL_W-1:0]  n_lvl;
    logic [l2t_pkg::LAT_W-1:0]  w_lat_mag;
    logic [l2t_pkg::MAG_W-1:0]  n_mag, r_mag;
    logic signed [l2t_pkg::U_W-1:0] n_u, r_u;

    // Stage 2
    logic [57:0]                w_rad_lo;
    logic [61:0]                w_rad;
    logic [l2t_pkg::ANG_W-1:0]  r_angle;
    logic [55:0]                w_xnum;
    logic [l2t_pkg::W_W-1:0]    r_w;

    // Stages 3 and 4, column
    logic                       r_xneg, r_xbig;
    logic [58:0]                r_xprod;
    logic [23:0]                w_xmax;

    // Sine and logs
    logic [l2t_pkg::FRAC_W-1:0] w_sine;
    logic [l2t_pkg::ANG_W-1:0]  w_one_plus, w_one_minus;
    l2t_pkg::t_log              w_log_hi, w_log_lo;

    // Row tail
    logic signed [36:0]         w_lg;
    logic [l2t_pkg::LG_W-1:0]   r_lg;
    logic [62:0]                w_dprod;
    logic [l2t_pkg::D_W-1:0]    r_d;
    logic [l2t_pkg::Y_W-1:0]    r_y;
    logic [55:0]                w_ynum;
    logic [24:0]                w_yq, w_ymax;
    logic [l2t_pkg::TILE_W-1:0] w_ty;
    logic [l2t_pkg::QK_W-1:0]   w_qk;

    // Output register
    logic [l2t_pkg::TILE_W-1:0] r_col, r_row;
    logic [l2t_pkg::QK_W-1:0]   r_qk;

    assign w_en    = !(r_vld[DEPTH] && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-1:1], i_valid};
        end
    end

    // ---- Stage 1: saturate level, fold latitude to a clamped magnitude,
    // bias longitude so the west edge lands on zero.
    always_comb begin
        n_lvl = (i_zoom_level > l2t_pkg::LVL_W'(l2t_pkg::MAX_LEVEL))
              ? l2t_pkg::LVL_W'(l2t_pkg::MAX_LEVEL) : i_zoom_level;
        w_lat_mag = i_latitude[l2t_pkg::LAT_W-1]
                  ? (~i_latitude + l2t_pkg::LAT_W'(1)) : i_latitude;
        n_mag = (w_lat_mag > l2t_pkg::LAT_W'(l2t_pkg::LAT_LIMIT))
              ? l2t_pkg::LAT_LIMIT : w_lat_mag[l2t_pkg::MAG_W-1:0];
        n_u = $signed({i_longitude[l2t_pkg::LON_W-1], i_longitude})
            + $signed(l2t_pkg::LON_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag <= n_mag;
            r_u   <= n_u;
        end
    end

    // Advance the side lines; level follows each beat to the end, hemisphere up to the Y stage.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lvl_d[1]   <= n_lvl;
            r_south_d[1] <= i_latitude[l2t_pkg::LAT_W-1];
            for (int k = 2; k <= DEPTH; k++) begin
                r_lvl_d[k] <= r_lvl_d[k-1];
            end
            for (int k = 2; k <= l2t_pkg::STG_Y - 1; k++) begin
                r_south_d[k] <= r_south_d[k-1];
            end
            for (int k = l2t_pkg::STG_TX + 1; k <= DEPTH - 1; k++) begin
                r_tx_d[k] <= r_tx_d[k-1];
            end
        end
    end

    // ---- Stage 2: degrees to Q30 radians (rounded); column numerator
    // (u << level) + bias, keep floor(. / 2^25).
    assign w_rad_lo = 58'(r_mag) * 58'(l2t_pkg::RAD_LO);
    assign w_rad    = 62'(w_rad_lo) + {1'b0, r_mag, 32'd0} + (62'd1 << 29);
    assign w_xnum   = ({{24{r_u[l2t_pkg::U_W-1]}}, r_u} << r_lvl_d[1])
                    + 56'(l2t_pkg::X_BIAS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_angle <= w_rad[60:30];
            r_w     <= w_xnum[55:25];
        end
    end

    // ---- Stage 3: divide by 45 through the reciprocal, flag the clamps.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xneg  <= r_w[l2t_pkg::W_W-1];
            r_xbig  <= !r_w[l2t_pkg::W_W-1]
                    && (r_w[29:0] >= (30'(l2t_pkg::COL_DIV) << r_lvl_d[2]));
            r_xprod <= 59'(r_w[28:0]) * 59'(l2t_pkg::COL_MUL);
        end
    end

    // ---- Stage 4: tile column, clamped to the map.
    assign w_xmax = (24'd1 << r_lvl_d[3]) - 24'd1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_xneg) begin
                r_tx_d[l2t_pkg::STG_TX] <= '0;
            end else if (r_xbig) begin
                r_tx_d[l2t_pkg::STG_TX] <= w_xmax[l2t_pkg::TILE_W-1:0];
            end else begin
                r_tx_d[l2t_pkg::STG_TX] <= l2t_pkg::TILE_W'(r_xprod >> l2t_pkg::COL_SHF);
            end
        end
    end

    // ---- Sine of the latitude angle.
    l2t_sine u_sine (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_angle),
        .o_sine  (w_sine)
    );

    // ---- log2(1+s) and log2(1-s) side by side.
    assign w_one_plus  = {1'b1, w_sine};
    assign w_one_minus = (l2t_pkg::ANG_W'(1) << l2t_pkg::FRAC_W) - {1'b0, w_sine};

    l2t_log2 u_log_hi (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_value (w_one_plus),
        .o_log   (w_log_hi)
    );

    l2t_log2 u_log_lo (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_value (w_one_minus),
        .o_log   (w_log_lo)
    );

    // ---- Log difference, floored at zero.
    assign w_lg = $signed({7'd0, w_log_hi.frac})
                - $signed({2'd0, w_log_hi.exp_neg, 30'd0})
                - $signed({7'd0, w_log_lo.frac})
                + $signed({2'd0, w_log_lo.exp_neg, 30'd0});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lg <= (w_lg < 0) ? '0 : w_lg[l2t_pkg::LG_W-1:0];
        end
    end

    // ---- Mercator offset in Q40.
    assign w_dprod = 63'(r_lg) * 63'(l2t_pkg::MERC_C);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d <= w_dprod[62:22];
        end
    end

    // ---- Y from the equator: north subtracts the offset, south adds it.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_south_d[l2t_pkg::STG_Y-1]) begin
                r_y <= (l2t_pkg::Y_W'(1) << l2t_pkg::HALF_BIT) + l2t_pkg::Y_W'(r_d);
            end else begin
                r_y <= (l2t_pkg::Y_W'(1) << l2t_pkg::HALF_BIT) - l2t_pkg::Y_W'(r_d);
            end
        end
    end

    // ---- Output stage: tile row, clamp, interleave the quadkey digits.
    assign w_ynum = (56'(r_y[41:9]) << r_lvl_d[DEPTH-1]) + (56'd1 << 22);
    assign w_yq   = w_ynum[55:31];
    assign w_ymax = (25'd1 << r_lvl_d[DEPTH-1]) - 25'd1;

    always_comb begin
        if (r_y[l2t_pkg::Y_W-1]) begin
            w_ty = '0;
        end else if (w_yq > w_ymax) begin
            w_ty = w_ymax[l2t_pkg::TILE_W-1:0];
        end else begin
            w_ty = w_yq[l2t_pkg::TILE_W-1:0];
        end
    end

    // Column bit low, row bit high; bits above the level are zero already.
    always_comb begin
        for (int j = 0; j < l2t_pkg::TILE_W; j++) begin
            w_qk[2*j]     = r_tx_d[DEPTH-1][j];
            w_qk[2*j + 1] = w_ty[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_col <= r_tx_d[DEPTH-1];
            r_row <= w_ty;
            r_qk  <= w_qk;
        end
    end

    assign o_valid       = r_vld[DEPTH];
    assign o_tile_column = r_col;
    assign o_tile_row    = r_row;
    assign o_quad_key    = r_qk;

    // ---- Checks
    `ASSERT_IMPL(a_col_in_map, r_vld[DEPTH], (o_tile_column >> r_lvl_d[DEPTH]) == '0, "column beyond map width")
    `ASSERT_IMPL(a_row_in_map, r_vld[DEPTH], (o_tile_row >> r_lvl_d[DEPTH]) == '0, "row beyond map height")
    `ASSERT_NEXT(a_hold_on_stall, r_vld[DEPTH] && i_stall, $stable(r_vld) && $stable(r_tx_d[l2t_pkg::STG_TX]), "pipeline moved while output beat held")

endmodule

>>> rtl/l2t_sine.sv
// Pipelined Q30 sine by truncated Taylor series, two stages per term.
// Depends on l2t_pkg.
module l2t_sine (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [l2t_pkg::ANG_W-1:0]   i_angle,
    output logic [l2t_pkg::FRAC_W-1:0]  o_sine
);

    logic        [31:0] r_r2   [0:l2t_pkg::SIN_TERMS];
    logic        [31:0] r_term [0:l2t_pkg::SIN_TERMS];
    logic signed [33:0] r_acc  [0:l2t_pkg::SIN_TERMS];
    logic        [31:0] r_r2a  [1:l2t_pkg::SIN_TERMS];
    logic        [31:0] r_p    [1:l2t_pkg::SIN_TERMS];
    logic signed [33:0] r_acca [1:l2t_pkg::SIN_TERMS];
    logic [l2t_pkg::FRAC_W-1:0] r_sine;
    logic signed [33:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r2[0]   <= 32'((64'(i_angle) * 64'(i_angle)) >> 30);
            r_term[0] <= 32'(i_angle);
            r_acc[0]  <= '0;
        end
    end

    for (genvar k = 1; k <= l2t_pkg::SIN_TERMS; k++) begin : g_term
        logic signed [33:0] w_step;
        logic        [64:0] w_quo;

        // add even terms, subtract odd ones
        if (((k - 1) % 2) == 0) begin : g_add
            assign w_step = r_acc[k-1] + $signed({2'b00, r_term[k-1]});
        end else begin : g_sub
            assign w_step = r_acc[k-1] - $signed({2'b00, r_term[k-1]});
        end

        assign w_quo = 65'(r_p[k]) * 65'(l2t_pkg::SIN_MUL[k-1]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r2a[k]  <= r_r2[k-1];
                r_p[k]    <= 32'((64'(r_term[k-1]) * 64'(r_r2[k-1])) >> 30);
                r_acca[k] <= w_step;
                r_r2[k]   <= r_r2a[k];
                r_term[k] <= 32'(w_quo >> l2t_pkg::SIN_SHF[k-1]);
                r_acc[k]  <= r_acca[k];
            end
        end
    end

    if ((l2t_pkg::SIN_TERMS % 2) == 0) begin : g_last_add
        assign n_sum = r_acc[l2t_pkg::SIN_TERMS]
                     + $signed({2'b00, r_term[l2t_pkg::SIN_TERMS]});
    end else begin : g_last_sub
        assign n_sum = r_acc[l2t_pkg::SIN_TERMS]
                     - $signed({2'b00, r_term[l2t_pkg::SIN_TERMS]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_sum < 0) begin
                r_sine <= '0;
            end else if (n_sum > $signed({4'b0000, {l2t_pkg::FRAC_W{1'b1}}})) begin
                r_sine <= '1;
            end else begin
                r_sine <= n_sum[l2t_pkg::FRAC_W-1:0];
            end
        end
    end

    assign o_sine = r_sine;

endmodule

>>> rtl/l2t_log2.sv
// Pipelined Q30 base-2 logarithm: one normalize stage, then one squaring per bit.
// Depends on l2t_pkg.
module l2t_log2 (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [l2t_pkg::ANG_W-1:0]  i_value,
    output l2t_pkg::t_log              o_log
);

    logic [l2t_pkg::ANG_W-1:0]  r_m [0:l2t_pkg::LOG_BITS];
    logic [l2t_pkg::FRAC_W-1:0] r_f [0:l2t_pkg::LOG_BITS];
    logic [l2t_pkg::EXP_W-1:0]  r_e [0:l2t_pkg::LOG_BITS];
    logic [l2t_pkg::ANG_W-1:0]  n_norm;
    logic [l2t_pkg::EXP_W-1:0]  n_shift;

    // Normalize to [1,2): shift left until the top bit is set.
    always_comb begin
        n_norm  = (i_value == '0) ? l2t_pkg::ANG_W'(1) : i_value;
        n_shift = '0;
        if (n_norm[30:15] == '0) begin
            n_norm  = n_norm << 16;
            n_shift = n_shift + 5'd16;
        end
        if (n_norm[30:23] == '0) begin
            n_norm  = n_norm << 8;
            n_shift = n_shift + 5'd8;
        end
        if (n_norm[30:27] == '0) begin
            n_norm  = n_norm << 4;
            n_shift = n_shift + 5'd4;
        end
        if (n_norm[30:29] == '0) begin
            n_norm  = n_norm << 2;
            n_shift = n_shift + 5'd2;
        end
        if (n_norm[30] == 1'b0) begin
            n_norm  = n_norm << 1;
            n_shift = n_shift + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= n_norm;
            r_f[0] <= '0;
            r_e[0] <= n_shift;
        end
    end

    for (genvar j = 1; j <= l2t_pkg::LOG_BITS; j++) begin : g_sq
        logic [61:0] w_sq;
        logic [31:0] w_t;

        assign w_sq = 62'(r_m[j-1]) * 62'(r_m[j-1]);
        assign w_t  = w_sq[61:30];

        // square overflowed past 2: emit a one and halve
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_e[j] <= r_e[j-1];
                if (w_t[31]) begin
                    r_m[j] <= w_t[31:1];
                    r_f[j] <= r_f[j-1] | (l2t_pkg::FRAC_W'(1) << (l2t_pkg::LOG_BITS - j));
                end else begin
                    r_m[j] <= w_t[30:0];
                    r_f[j] <= r_f[j-1];
                end
            end
        end
    end

    assign o_log.exp_neg = r_e[l2t_pkg::LOG_BITS];
    assign o_log.frac    = r_f[l2t_pkg::LOG_BITS];

endmodule
